@@ src/wdf_pkg.sv @@
`default_nettype none

package wdf_pkg;

    // Operand and quotient width
    localparam int WDF_W     = 32;
    localparam int WDF_CNT_W = $clog2(WDF_W);

    // Most negative signed word
    localparam logic [WDF_W-1:0] WDF_MOST_NEG = {1'b1, {(WDF_W-1){1'b0}}};

    // Divide kinds carried by func
    localparam logic FUNC_SIGNED   = 1'b0;
    localparam logic FUNC_UNSIGNED = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } wdf_state_t;

endpackage

`default_nettype wire

@@ src/wdf_divider.sv @@
`default_nettype none

// Radix-2 restoring divider on unsigned magnitudes, one quotient bit per cycle
module wdf_divider
    import wdf_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [WDF_W-1:0] dvd,
    input  wire logic [WDF_W-1:0] dvs,
    output logic                  done,
    output logic      [WDF_W-1:0] quo
);

    localparam logic [WDF_CNT_W-1:0] LAST_STEP = WDF_CNT_W'(WDF_W - 1);

    logic                 run_reg,  run_next;
    logic                 done_reg, done_next;
    logic [WDF_CNT_W-1:0] cnt_reg,  cnt_next;
    logic [WDF_W-1:0]     rem_reg,  rem_next;
    logic [WDF_W-1:0]     quo_reg,  quo_next;
    logic [WDF_W-1:0]     dvs_reg,  dvs_next;
    logic [WDF_W:0]       trial;
    logic                 fits;

    // Shared subtractor: shifted partial remainder minus divisor
    assign trial = {rem_reg, quo_reg[WDF_W-1]} - {1'b0, dvs_reg};
    assign fits  = ~trial[WDF_W];

    // Next-value logic for one step
    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            run_next = 1'b1;
            cnt_next = '0;
            rem_next = '0;
            quo_next = dvd;
            dvs_next = dvs;
        end else if (run_reg) begin
            rem_next = fits ? trial[WDF_W-1:0] : {rem_reg[WDF_W-2:0], quo_reg[WDF_W-1]};
            quo_next = {quo_reg[WDF_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

`default_nettype wire

@@ src/word_divide_with_flags.sv @@
`default_nettype none

// Channel   Direction  Handshake          Payload
// s_        in         s_valid / s_ready  func, dividend, divisor, check_overflow,
//                                         record_flags, target_index
// m_        out        m_valid / m_ready  write_target, target_reg, quotient,
//                                         ov_flag, so_flag, cr_field
//
// The result appears on m_ after the accepting edge once the radix-2 divider
// has produced its quotient (one quotient bit per step), the done pulse has
// reached the sequencer, and the sign and flags are fixed into the result
// register. s_ready is high only in the idle state, entered as the result
// register is loaded, so a new transaction is accepted only after the previous
// one has been loaded. A finished result held on m_ may wait while the next
// transaction is accepted; a stall on m_ holds the block in its final state.
// Synchronous active-low reset clears the overflow, summary and condition flags.
module word_divide_with_flags
    import wdf_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_func,
    input  wire logic [WDF_W-1:0] s_dividend,
    input  wire logic [WDF_W-1:0] s_divisor,
    input  wire logic             s_check_overflow,
    input  wire logic             s_record_flags,
    input  wire logic [4:0]       s_target_index,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic                  m_write_target,
    output logic      [4:0]       m_target_reg,
    output logic      [WDF_W-1:0] m_quotient,
    output logic                  m_ov_flag,
    output logic                  m_so_flag,
    output logic      [3:0]       m_cr_field
);

    wdf_state_t state_reg, state_next;

    logic             accept;
    logic             out_load;
    logic             div_done;
    logic [WDF_W-1:0] div_quo;

    // Captured transaction
    logic             uns_reg;
    logic             neg_reg;
    logic             chk_reg;
    logic             rec_reg;
    logic             ovf_reg;
    logic             bzero_reg;
    logic [4:0]       tgt_reg;

    // Architected flags
    logic             ov_reg, ov_next;
    logic             so_reg, so_next;
    logic [3:0]       cr_reg, cr_next;

    // Result register
    logic             mv_reg;
    logic             mw_reg;
    logic [4:0]       mt_reg;
    logic [WDF_W-1:0] mq_reg;

    // Operand magnitudes and overflow detection
    logic             na, nb, b_zero, ovf_in;
    logic [WDF_W-1:0] mag_a, mag_b;

    assign na     = (s_func == FUNC_SIGNED) & s_dividend[WDF_W-1];
    assign nb     = (s_func == FUNC_SIGNED) & s_divisor[WDF_W-1];
    assign mag_a  = na ? (~s_dividend + 1'b1) : s_dividend;
    assign mag_b  = nb ? (~s_divisor + 1'b1) : s_divisor;
    assign b_zero = (s_divisor == '0);
    assign ovf_in = b_zero | ((s_func == FUNC_SIGNED) & (s_dividend == WDF_MOST_NEG)
                              & (s_divisor == '1));

    wdf_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .dvd     (mag_a),
        .dvs     (mag_b),
        .done    (div_done),
        .quo     (div_quo)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_valid)  state_next = ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_FIN;
            ST_FIN:  if (out_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_ready  = 1'b0;
        accept   = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                accept  = s_valid;
            end
            ST_FIN:  out_load = ~mv_reg | m_ready;
            default: ;
        endcase
    end

    // Sign fix-up and flag update
    logic             q_neg, q_nz, skip;
    logic             lt, gt, eq;
    logic [WDF_W-1:0] q_fix;

    always_comb begin
        q_nz  = (div_quo != '0);
        q_neg = ~uns_reg & neg_reg & q_nz;
        q_fix = q_neg ? (~div_quo + 1'b1) : div_quo;
        if (bzero_reg) begin
            q_fix = '0;
            lt    = 1'b0;
            gt    = 1'b0;
            eq    = 1'b1;
        end else if (uns_reg) begin
            lt = q_fix[WDF_W-1];
            gt = ~q_fix[WDF_W-1] & q_nz;
            eq = ~q_nz;
        end else begin
            lt = q_neg;
            gt = ~q_neg & q_nz;
            eq = ~q_nz;
        end
        skip    = chk_reg & ovf_reg;
        ov_next = chk_reg ? ovf_reg : ov_reg;
        so_next = so_reg | skip;
        cr_next = cr_reg;
        if (rec_reg) begin
            cr_next = skip ? {cr_reg[3:1], so_next} : {lt, gt, eq, so_next};
        end
    end

    // Control state and flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
            so_reg    <= 1'b0;
            cr_reg    <= '0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                mv_reg <= 1'b1;
                ov_reg <= ov_next;
                so_reg <= so_next;
                cr_reg <= cr_next;
            end else if (m_ready) begin
                mv_reg <= 1'b0;
            end
        end
    end

    // Payload capture
    always_ff @(posedge aclk) begin
        if (accept) begin
            uns_reg   <= (s_func == FUNC_UNSIGNED);
            neg_reg   <= na ^ nb;
            chk_reg   <= s_check_overflow;
            rec_reg   <= s_record_flags;
            ovf_reg   <= ovf_in;
            bzero_reg <= b_zero;
            tgt_reg   <= s_target_index;
        end
        if (out_load) begin
            mw_reg <= ~skip;
            mt_reg <= tgt_reg;
            mq_reg <= skip ? '0 : q_fix;
        end
    end

    assign m_valid        = mv_reg;
    assign m_write_target = mw_reg;
    assign m_target_reg   = mt_reg;
    assign m_quotient     = mq_reg;
    assign m_ov_flag      = ov_reg;
    assign m_so_flag      = so_reg;
    assign m_cr_field     = cr_reg;

    // Divider finishes only while the sequencer waits for it
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider done outside divide state");

    // Summary overflow is sticky
    a_so_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        so_reg |=> so_reg)
        else $error("summary overflow cleared");

    // A suppressed write always comes with overflow set and a zero quotient
    a_skip_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        (mv_reg && !mw_reg) |-> (ov_reg && so_reg && mq_reg == '0))
        else $error("suppressed write without overflow");

    // Summary bit of the condition field tracks the sticky bit when recorded
    a_cr_so: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && rec_reg) |=> (cr_reg[0] == so_reg))
        else $error("condition summary bit mismatch");

endmodule

`default_nettype wire
